/* hw/rtl/pmft_pkg.sv */
package pmft_pkg;

    localparam int NUM_BLOCKS_DEF      = 16;
    localparam int PAGES_PER_BLOCK_DEF = 8;
    localparam int LOGICAL_PAGES_DEF   = 64;
    localparam int DATA_WIDTH_DEF      = 32;

    localparam int LP_W     = 6;
    localparam int DATA_W   = 32;
    localparam int PHYS_W   = 7;
    localparam int STATUS_W = 2;
    localparam int ERASED_W = 5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_WR_FAIL  = 2'd1;
    localparam logic [1:0] ST_UNMAPPED = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_MAP,
        S_RD_DATA,
        S_WR_SCAN,
        S_WR_STALE,
        S_GC_CHECK,
        S_GC_READ,
        S_GC_EVAL,
        S_GC_SCAN,
        S_GC_COPY,
        S_GC_ERASE,
        S_DONE
    } state_t;

endpackage

/* hw/rtl/page_mapped_flash_translation_unit.sv */
// Page-mapped flash translation unit.
// Command channel: drive req_type, logical_page and write_data with start high
// while busy is low; the transaction is taken at that clock edge and busy rises.
// One result per transaction: read_data, found, phys_page, status and
// blocks_erased are shown for exactly one cycle with done high. The receiver
// cannot stall; it must sample on done.
// A read passes through map memory read, page memory read and result, or goes
// straight from the map memory read to the result when the page is unmapped.
// A write scans the used bitmap one page per cycle from page 0 until the first
// free page and then updates the map; when no page is free it stops at the last
// page. Both then check for collection. Each collected block reads and evaluates
// each of its pages; for each live page a free-page scan from page 0 stops on a
// free page outside the victim (or the last page) and a copy step follows.
// The next transaction can be taken in the cycle after done.
// Page data and its owner sit in one synchronous memory and map targets in
// another, each read synchronously; used, stale and map-valid bits are flops.
// Reset clears the valid bits, the victim pointer and the used count at once;
// no clearing pass is needed. Only one transaction is in flight at a time.
module page_mapped_flash_translation_unit #(
    parameter int NUM_BLOCKS      = pmft_pkg::NUM_BLOCKS_DEF,
    parameter int PAGES_PER_BLOCK = pmft_pkg::PAGES_PER_BLOCK_DEF,
    parameter int LOGICAL_PAGES   = pmft_pkg::LOGICAL_PAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           req_type,
    input  logic [pmft_pkg::LP_W-1:0]      logical_page,
    input  logic [pmft_pkg::DATA_W-1:0]    write_data,
    output logic                           done,
    output logic [pmft_pkg::DATA_W-1:0]    read_data,
    output logic                           found,
    output logic [pmft_pkg::PHYS_W-1:0]    phys_page,
    output logic [pmft_pkg::STATUS_W-1:0]  status,
    output logic [pmft_pkg::ERASED_W-1:0]  blocks_erased
);

    localparam int TOTAL  = NUM_BLOCKS * PAGES_PER_BLOCK;
    localparam int PW     = $clog2(TOTAL);
    localparam int OFF_W  = $clog2(PAGES_PER_BLOCK);
    localparam int BLK_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(TOTAL + 1);
    localparam int MAPD   = (LOGICAL_PAGES < 64) ? LOGICAL_PAGES : 64;
    localparam int MW     = (MAPD > 1) ? $clog2(MAPD) : 1;
    localparam int NB_W   = $clog2(NUM_BLOCKS + 1);
    localparam logic [CNT_W-1:0] THRESH = CNT_W'(TOTAL - (PAGES_PER_BLOCK + 1));

    // Memories
    logic [pmft_pkg::LP_W+pmft_pkg::DATA_W-1:0] page_mem [TOTAL];
    logic [PW-1:0]                              map_mem  [MAPD];

    logic [TOTAL-1:0] used_reg, used_next;
    logic [TOTAL-1:0] stale_reg, stale_next;
    logic [MAPD-1:0]  mvalid_reg, mvalid_next;

    pmft_pkg::state_t state_reg, state_next;
    logic [BLK_W-1:0] victim_reg, victim_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic                        req_reg;
    logic [pmft_pkg::LP_W-1:0]   lp_reg;
    logic [pmft_pkg::DATA_W-1:0] wdata_reg;
    logic [PW-1:0]               scan_reg, scan_next;
    logic [OFF_W-1:0]            off_reg, off_next;
    logic [NB_W-1:0]             nerased_reg, nerased_next;
    logic [pmft_pkg::DATA_W-1:0] rdata_reg, rdata_next;
    logic                        found_reg, found_next;
    logic [PW-1:0]               phys_reg, phys_next;
    logic [1:0]                  status_reg, status_next;

    // Memory ports
    logic                        st_we, mp_we;
    logic [PW-1:0]               st_wa, st_ra;
    logic [pmft_pkg::DATA_W-1:0] st_wd, st_rd;
    logic [pmft_pkg::LP_W-1:0]   ow_wd, ow_rd;
    logic [MW-1:0]               mp_a;
    logic [PW-1:0]               mp_wd, mp_rd;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            page_mem[st_wa] <= {ow_wd, st_wd};
        end
        {ow_rd, st_rd} <= page_mem[st_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mp_we)
        begin
            map_mem[mp_a] <= mp_wd;
        end
        mp_rd <= map_mem[mp_a];
    end

    logic            lp_ok;
    logic [MW-1:0]   lp_idx;
    logic [PW-1:0]   victim_base;
    logic [PW-1:0]   vpage;
    logic            scan_in_victim;
    logic            owner_ok;
    logic [MW-1:0]   owner_idx;

    assign lp_ok       = {26'd0, lp_reg} < 32'(LOGICAL_PAGES);
    assign lp_idx      = MW'(lp_reg);
    assign owner_ok    = {26'd0, ow_rd} < 32'(LOGICAL_PAGES);
    assign owner_idx   = MW'(ow_rd);
    assign victim_base = PW'(32'(victim_reg) * PAGES_PER_BLOCK);
    assign vpage       = victim_base + PW'(off_reg);
    assign scan_in_victim = (32'(scan_reg) >= 32'(victim_base))
                         && (32'(scan_reg) < 32'(victim_base) + PAGES_PER_BLOCK);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmft_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = (req_type == pmft_pkg::REQ_READ) ? pmft_pkg::S_RD_MAP
                                                                   : pmft_pkg::S_WR_SCAN;
                end
            end
            pmft_pkg::S_RD_MAP:
            begin
                state_next = (lp_ok && mvalid_reg[lp_idx]) ? pmft_pkg::S_RD_DATA
                                                           : pmft_pkg::S_DONE;
            end
            pmft_pkg::S_RD_DATA:   state_next = pmft_pkg::S_DONE;
            pmft_pkg::S_WR_SCAN:
            begin
                if (!lp_ok)
                begin
                    state_next = pmft_pkg::S_DONE;
                end
                else if (!used_reg[scan_reg])
                begin
                    state_next = pmft_pkg::S_WR_STALE;
                end
                else if (32'(scan_reg) == TOTAL - 1)
                begin
                    state_next = pmft_pkg::S_GC_CHECK;
                end
            end
            pmft_pkg::S_WR_STALE:  state_next = pmft_pkg::S_GC_CHECK;
            pmft_pkg::S_GC_CHECK:
            begin
                state_next = (count_reg == THRESH && 32'(nerased_reg) < NUM_BLOCKS)
                             ? pmft_pkg::S_GC_READ : pmft_pkg::S_DONE;
            end
            pmft_pkg::S_GC_READ:   state_next = pmft_pkg::S_GC_EVAL;
            pmft_pkg::S_GC_EVAL:
            begin
                if (used_reg[vpage] && !stale_reg[vpage])
                begin
                    state_next = pmft_pkg::S_GC_SCAN;
                end
                else if (32'(off_reg) == PAGES_PER_BLOCK - 1)
                begin
                    state_next = pmft_pkg::S_GC_ERASE;
                end
                else
                begin
                    state_next = pmft_pkg::S_GC_READ;
                end
            end
            pmft_pkg::S_GC_SCAN:
            begin
                if ((!scan_in_victim && !used_reg[scan_reg]) || 32'(scan_reg) == TOTAL - 1)
                begin
                    state_next = pmft_pkg::S_GC_COPY;
                end
            end
            pmft_pkg::S_GC_COPY:
            begin
                state_next = (32'(off_reg) == PAGES_PER_BLOCK - 1) ? pmft_pkg::S_GC_ERASE
                                                                    : pmft_pkg::S_GC_READ;
            end
            pmft_pkg::S_GC_ERASE:  state_next = pmft_pkg::S_GC_CHECK;
            pmft_pkg::S_DONE:      state_next = pmft_pkg::S_IDLE;
            default:               state_next = pmft_pkg::S_IDLE;
        endcase
    end

    logic copy_ok;
    assign copy_ok = !scan_in_victim && !used_reg[scan_reg];

    always_comb
    begin
        used_next    = used_reg;
        stale_next   = stale_reg;
        mvalid_next  = mvalid_reg;
        victim_next  = victim_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        off_next     = off_reg;
        nerased_next = nerased_reg;
        rdata_next   = rdata_reg;
        found_next   = found_reg;
        phys_next    = phys_reg;
        status_next  = status_reg;
        st_we = 1'b0;
        mp_we = 1'b0;
        st_wa = scan_reg;
        st_wd = wdata_reg;
        ow_wd = lp_reg;
        st_ra = vpage;
        mp_a  = lp_idx;
        mp_wd = scan_reg;
        unique case (state_reg)
            pmft_pkg::S_IDLE:
            begin
                scan_next    = '0;
                off_next     = '0;
                nerased_next = '0;
                rdata_next   = '0;
                found_next   = 1'b0;
                phys_next    = '0;
                status_next  = pmft_pkg::ST_OK;
            end
            pmft_pkg::S_RD_MAP:
            begin
                if (!(lp_ok && mvalid_reg[lp_idx]))
                begin
                    status_next = pmft_pkg::ST_UNMAPPED;
                end
            end
            pmft_pkg::S_RD_DATA:
            begin
                st_ra = mp_rd;
            end
            pmft_pkg::S_WR_SCAN:
            begin
                if (!lp_ok)
                begin
                    status_next = pmft_pkg::ST_WR_FAIL;
                end
                else if (!used_reg[scan_reg])
                begin
                    st_we = 1'b1;
                    used_next[scan_reg]  = 1'b1;
                    stale_next[scan_reg] = 1'b0;
                    count_next = count_reg + CNT_W'(1);
                    phys_next  = scan_reg;
                end
                else if (32'(scan_reg) == TOTAL - 1)
                begin
                    status_next = pmft_pkg::ST_WR_FAIL;
                end
                else
                begin
                    scan_next = scan_reg + PW'(1);
                end
            end
            pmft_pkg::S_WR_STALE:
            begin
                // mp_rd holds the old target, read during the scan.
                if (mvalid_reg[lp_idx])
                begin
                    stale_next[mp_rd] = 1'b1;
                end
                mp_we = 1'b1;
                mp_wd = phys_reg;
                mvalid_next[lp_idx] = 1'b1;
            end
            pmft_pkg::S_GC_CHECK:
            begin
                off_next = '0;
            end
            pmft_pkg::S_GC_EVAL:
            begin
                if (used_reg[vpage] && !stale_reg[vpage])
                begin
                    scan_next = '0;
                end
                else
                begin
                    if (used_reg[vpage])
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    off_next = off_reg + OFF_W'(1);
                end
            end
            pmft_pkg::S_GC_SCAN:
            begin
                if (!copy_ok && 32'(scan_reg) != TOTAL - 1)
                begin
                    scan_next = scan_reg + PW'(1);
                end
            end
            pmft_pkg::S_GC_COPY:
            begin
                // st_rd and ow_rd still hold the victim page read in S_GC_READ.
                mp_a = owner_idx;
                if (copy_ok)
                begin
                    st_we = 1'b1;
                    st_wd = st_rd;
                    ow_wd = ow_rd;
                    used_next[scan_reg]  = 1'b1;
                    stale_next[scan_reg] = 1'b0;
                    mp_we = owner_ok;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    if (owner_ok)
                    begin
                        mvalid_next[owner_idx] = 1'b0;
                    end
                end
                off_next = off_reg + OFF_W'(1);
            end
            pmft_pkg::S_GC_ERASE:
            begin
                for (int i = 0; i < PAGES_PER_BLOCK; i++)
                begin
                    used_next[victim_base + PW'(i)]  = 1'b0;
                    stale_next[victim_base + PW'(i)] = 1'b0;
                end
                victim_next  = (32'(victim_reg) == NUM_BLOCKS - 1) ? '0
                                                                  : victim_reg + BLK_W'(1);
                nerased_next = nerased_reg + NB_W'(1);
            end
            pmft_pkg::S_DONE:
            begin
                if (!req_reg && status_reg == pmft_pkg::ST_OK)
                begin
                    rdata_next = '0;
                end
            end
            default:
            begin
            end
        endcase
        if (state_reg == pmft_pkg::S_RD_DATA)
        begin
            phys_next  = mp_rd;
            found_next = 1'b1;
        end
    end

    // Read data arrives in the cycle after S_RD_DATA addresses the page memory.
    logic rd_data_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pmft_pkg::S_IDLE;
            used_reg    <= '0;
            stale_reg   <= '0;
            mvalid_reg  <= '0;
            victim_reg  <= '0;
            count_reg   <= '0;
            rd_data_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            stale_reg   <= stale_next;
            mvalid_reg  <= mvalid_next;
            victim_reg  <= victim_next;
            count_reg   <= count_next;
            rd_data_pending_reg <= (state_reg == pmft_pkg::S_RD_DATA);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == pmft_pkg::S_IDLE && start)
        begin
            req_reg   <= req_type;
            lp_reg    <= logical_page;
            wdata_reg <= write_data;
        end
        scan_reg    <= scan_next;
        off_reg     <= off_next;
        nerased_reg <= nerased_next;
        rdata_reg   <= rdata_next;
        found_reg   <= found_next;
        phys_reg    <= phys_next;
        status_reg  <= status_next;
    end

    assign busy          = (state_reg != pmft_pkg::S_IDLE);
    assign done          = (state_reg == pmft_pkg::S_DONE);
    assign read_data     = rd_data_pending_reg ? st_rd : rdata_reg;
    assign found         = found_reg;
    assign phys_page     = pmft_pkg::PHYS_W'(phys_reg);
    assign status        = status_reg;
    assign blocks_erased = pmft_pkg::ERASED_W'(nerased_reg);

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= TOTAL)
        else $error("used count exceeds page total");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> status == pmft_pkg::ST_OK)
        else $error("found set on failed request");

    a_erase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(nerased_reg) <= NUM_BLOCKS)
        else $error("too many blocks collected");

endmodule
